// ===== hdl/ttg_pkg.sv =====
// ============================================================================
// Thermal throttle governor package
// Shared widths, reset values, register indexes and beat types.
// ============================================================================
package ttg_pkg;

    // Width of a temperature reading in millidegrees.
    localparam int TEMP_W = 18;
    localparam int OPP_W  = 8;
    localparam int CNT_W  = 8;

    // Configuration data is as wide as the widest register.
    localparam int CFG_W   = (TEMP_W > CNT_W) ? TEMP_W : CNT_W;
    localparam int CFG_IDX_W = 3;

    // Reset values saturate to the largest reading the field can hold.
    localparam longint unsigned TEMP_MAX = (64'd1 << TEMP_W) - 64'd1;
    localparam logic [TEMP_W-1:0] WARM_RST =
        TEMP_W'((80000 > TEMP_MAX) ? TEMP_MAX : 64'd80000);
    localparam logic [TEMP_W-1:0] HOT_RST =
        TEMP_W'((90000 > TEMP_MAX) ? TEMP_MAX : 64'd90000);
    localparam logic [TEMP_W-1:0] CRIT_RST =
        TEMP_W'((100000 > TEMP_MAX) ? TEMP_MAX : 64'd100000);
    localparam logic [TEMP_W-1:0] MARGIN_RST =
        TEMP_W'((5000 > TEMP_MAX) ? TEMP_MAX : 64'd5000);
    localparam logic [CNT_W-1:0] DWELL_RST = CNT_W'(5);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARM_LIMIT     = 3'd0,
        REG_HOT_LIMIT      = 3'd1,
        REG_CRITICAL_LIMIT = 3'd2,
        REG_COOL_MARGIN    = 3'd3,
        REG_DWELL_POLLS    = 3'd4,
        REG_SCALING_ENABLE = 3'd5
    } t_cfg_idx;

    // Current configuration as seen by the decision logic.
    typedef struct packed {
        logic [TEMP_W-1:0] warm_limit;
        logic [TEMP_W-1:0] hot_limit;
        logic [TEMP_W-1:0] critical_limit;
        logic [TEMP_W-1:0] cool_margin;
        logic [CNT_W-1:0]  dwell_polls;
        logic              scaling_enable;
    } t_cfg;

    // One sensor beat.
    typedef struct packed {
        logic [TEMP_W-1:0] sensor_temp;
        logic              reading_ok;
        logic              last_sensor;
        logic [OPP_W-1:0]  current_opp;
    } t_item;

    // One decision beat.
    typedef struct packed {
        logic             shutdown_request;
        logic             opp_write;
        logic [OPP_W-1:0] opp_value;
        logic             throttled;
    } t_result;

endpackage

// ===== hdl/ttg_in_if.sv =====
// ============================================================================
// Sensor channel interface
// Valid/ready channel carrying one sensor reading per beat.
// ============================================================================
interface ttg_in_if;
    import ttg_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] sensor_temp;
    logic              reading_ok;
    logic              last_sensor;
    logic [OPP_W-1:0]  current_opp;

    modport source (
        output valid, sensor_temp, reading_ok, last_sensor, current_opp,
        input  ready
    );
    modport sink (
        input  valid, sensor_temp, reading_ok, last_sensor, current_opp,
        output ready
    );
endinterface

// ===== hdl/ttg_out_if.sv =====
// ============================================================================
// Decision channel interface
// Valid/ready channel carrying one governor decision per beat.
// ============================================================================
interface ttg_out_if;
    import ttg_pkg::*;

    logic             valid;
    logic             ready;
    logic             shutdown_request;
    logic             opp_write;
    logic [OPP_W-1:0] opp_value;
    logic             throttled;

    modport source (
        output valid, shutdown_request, opp_write, opp_value, throttled,
        input  ready
    );
    modport sink (
        input  valid, shutdown_request, opp_write, opp_value, throttled,
        output ready
    );
endinterface

// ===== hdl/ttg_cfg.sv =====
// ============================================================================
// Governor configuration registers
// Holds thresholds, dwell count and scaling enable; written by index.
// ============================================================================
module ttg_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttg_pkg::CFG_W-1:0]      i_cfg_data,
    output ttg_pkg::t_cfg                  o_cfg
);
    import ttg_pkg::*;

    t_cfg r_cfg;

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warm_limit     <= WARM_RST;
            r_cfg.hot_limit      <= HOT_RST;
            r_cfg.critical_limit <= CRIT_RST;
            r_cfg.cool_margin    <= MARGIN_RST;
            r_cfg.dwell_polls    <= DWELL_RST;
            r_cfg.scaling_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_WARM_LIMIT:     r_cfg.warm_limit     <= i_cfg_data[TEMP_W-1:0];
                REG_HOT_LIMIT:      r_cfg.hot_limit      <= i_cfg_data[TEMP_W-1:0];
                REG_CRITICAL_LIMIT: r_cfg.critical_limit <= i_cfg_data[TEMP_W-1:0];
                REG_COOL_MARGIN:    r_cfg.cool_margin    <= i_cfg_data[TEMP_W-1:0];
                REG_DWELL_POLLS:    r_cfg.dwell_polls    <= i_cfg_data[CNT_W-1:0];
                REG_SCALING_ENABLE: r_cfg.scaling_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ttg_core.sv =====
// ============================================================================
// Governor decision core
// Tracks the hottest reading of a poll and applies the throttle rules.
// ============================================================================
module ttg_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ttg_pkg::t_item   i_item,
    input  ttg_pkg::t_cfg    i_cfg,
    output ttg_pkg::t_result o_result
);
    import ttg_pkg::*;

    logic [TEMP_W-1:0] r_hottest, n_hottest;
    logic [OPP_W-1:0]  r_captured, n_captured;
    logic [OPP_W-1:0]  r_steps, n_steps;
    logic [CNT_W-1:0]  r_warm_cnt, n_warm_cnt;
    logic [CNT_W-1:0]  r_cool_cnt, n_cool_cnt;

    logic [TEMP_W-1:0] hot_now;
    logic [TEMP_W:0]   cool_sum;
    logic [OPP_W-1:0]  cap_try;
    logic              up_blocked;
    logic              try_up;
    logic              up_full;
    logic [CNT_W-1:0]  warm_inc;
    logic [CNT_W-1:0]  cool_inc;
    logic              write;

    // Hottest valid reading including this beat.
    assign hot_now = (i_item.reading_ok && (i_item.sensor_temp > r_hottest))
                     ? i_item.sensor_temp : r_hottest;
    assign cool_sum = {1'b0, hot_now} + {1'b0, i_cfg.cool_margin};
    assign warm_inc = r_warm_cnt + CNT_W'(1);
    assign cool_inc = r_cool_cnt + CNT_W'(1);

    // The operating point is captured on a step up from an unthrottled state.
    assign cap_try    = ((r_steps == '0) && i_cfg.scaling_enable)
                        ? i_item.current_opp : r_captured;
    assign up_blocked = (r_steps == cap_try) || (cap_try == '0);

    // Hottest tracking within a poll, rule evaluation at the end of a poll.
    always_comb begin
        n_hottest  = r_hottest;
        n_captured = r_captured;
        n_steps    = r_steps;
        n_warm_cnt = r_warm_cnt;
        n_cool_cnt = r_cool_cnt;
        try_up     = 1'b0;
        up_full    = 1'b0;
        write      = 1'b0;
        o_result   = '0;

        if (!i_item.last_sensor) begin
            n_hottest = hot_now;
        end else begin
            n_hottest = '0;
            priority if (hot_now >= i_cfg.critical_limit) begin
                o_result.shutdown_request = 1'b1;
            end else if (hot_now >= i_cfg.hot_limit) begin
                try_up  = 1'b1;
                up_full = 1'b1;
            end else if (hot_now >= i_cfg.warm_limit) begin
                n_warm_cnt = warm_inc;
                try_up     = (warm_inc >= i_cfg.dwell_polls);
            end else if (cool_sum < {1'b0, i_cfg.warm_limit}) begin
                n_cool_cnt = cool_inc;
                if ((cool_inc >= i_cfg.dwell_polls) && (r_steps != '0)
                        && (r_captured != '0)) begin
                    n_steps    = r_steps - OPP_W'(1);
                    n_warm_cnt = '0;
                    n_cool_cnt = '0;
                    write      = i_cfg.scaling_enable;
                end
            end else begin
                // Between the cool and warm bands nothing changes.
            end

            // Step up, shared by the hot and warm rules.
            if (try_up) begin
                n_captured = cap_try;
                if (!up_blocked) begin
                    n_steps    = up_full ? cap_try : (r_steps + OPP_W'(1));
                    n_warm_cnt = '0;
                    n_cool_cnt = '0;
                    write      = i_cfg.scaling_enable;
                end
            end

            o_result.opp_write = write;
            o_result.opp_value = write ? (n_captured - n_steps) : '0;
            o_result.throttled = (n_steps != '0);
        end
    end

    // Governor state advances once per processed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hottest  <= '0;
            r_captured <= '0;
            r_steps    <= '0;
            r_warm_cnt <= '0;
            r_cool_cnt <= '0;
        end else if (i_fire) begin
            r_hottest  <= n_hottest;
            r_captured <= n_captured;
            r_steps    <= n_steps;
            r_warm_cnt <= n_warm_cnt;
            r_cool_cnt <= n_cool_cnt;
        end
    end

    // The throttle level never exceeds the captured operating point.
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= r_captured)
        else $error("throttle level above captured operating point");

    // A shutdown decision leaves the throttle level and counters alone.
    a_shutdown_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.last_sensor && (hot_now >= i_cfg.critical_limit))
        |=> ($stable(r_steps) && $stable(r_warm_cnt) && $stable(r_cool_cnt)))
        else $error("shutdown changed throttle state");

    // The hottest reading is cleared after every closed poll.
    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.last_sensor) |=> (r_hottest == '0))
        else $error("hottest reading not cleared at end of poll");

endmodule

// ===== hdl/thermal_throttle_governor_unit.sv =====
// An accepted last-of-poll beat passes the input register, the decision core
// and the result register before it leaves as its decision beat. Throughput:
// one sensor beat per cycle while no closing beat waits on a stalled result.
// Reset (synchronous, active low) clears the governor state and both stage
// valids, and loads the configuration registers with their default values.
// ============================================================================
// Thermal throttle governor top level
// Input stage, decision core and result register with valid/ready channels.
// ============================================================================
module thermal_throttle_governor_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttg_pkg::CFG_W-1:0]      i_cfg_data,
    ttg_in_if.sink                         i_item,
    ttg_out_if.source                      o_result
);
    import ttg_pkg::*;

    t_cfg    cfg;
    t_item   r_in_q;
    logic    r_in_valid;
    t_result core_result;
    t_result r_out_q;
    logic    r_out_valid;
    logic    in_accept;
    logic    stage_fire;

    ttg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // A beat without a decision never waits; a closing beat needs a free slot.
    assign stage_fire = r_in_valid
                        && (!r_in_q.last_sensor || !r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || stage_fire;
    assign in_accept    = i_item.valid && i_item.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (stage_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_q.sensor_temp <= i_item.sensor_temp;
            r_in_q.reading_ok  <= i_item.reading_ok;
            r_in_q.last_sensor <= i_item.last_sensor;
            r_in_q.current_opp <= i_item.current_opp;
        end
    end

    ttg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (stage_fire),
        .i_item   (r_in_q),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_fire && r_in_q.last_sensor) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire && r_in_q.last_sensor) begin
            r_out_q <= core_result;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.shutdown_request = r_out_q.shutdown_request;
    assign o_result.opp_write        = r_out_q.opp_write;
    assign o_result.opp_value        = r_out_q.opp_value;
    assign o_result.throttled        = r_out_q.throttled;

    // A new decision beat only follows a processed last-of-poll beat.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(stage_fire && r_in_q.last_sensor))
        else $error("decision beat without a closing sensor beat");

    // A closing beat stays in the input stage while the result is stalled.
    a_close_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_q.last_sensor && r_out_valid && !o_result.ready)
        |=> r_in_valid)
        else $error("closing beat dropped while result stalled");

    // A stalled decision beat is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !(stage_fire && r_in_q.last_sensor))
        else $error("decision overwritten while stalled");

endmodule
